@@ rtl/xaf_pkg.sv @@
// ----------------------------------------------------------------------------
// xaf_pkg
// Shared types, constants and the parser state codes of the attribute filter.
// ----------------------------------------------------------------------------
package xaf_pkg;

    localparam int SKIP_ENTRIES_DEF = 8;
    localparam int MAX_NAME_DEF     = 32;

    // Parser states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_NAME      = 4'd1;
    localparam logic [3:0] ST_NAME_END  = 4'd2;
    localparam logic [3:0] ST_PNAME     = 4'd3;
    localparam logic [3:0] ST_PNAME_END = 4'd4;
    localparam logic [3:0] ST_EQU       = 4'd5;
    localparam logic [3:0] ST_VAL       = 4'd6;
    localparam logic [3:0] ST_TAG_END   = 4'd7;

    // Input modes
    localparam logic [1:0] MODE_STREAM  = 2'd0;
    localparam logic [1:0] MODE_SKIPCHR = 2'd1;
    localparam logic [1:0] MODE_SKIPLEN = 2'd2;
    localparam logic [1:0] MODE_IGNORE  = 2'd3;

    localparam logic [7:0] CH_LT  = 8'h3c;
    localparam logic [7:0] CH_GT  = 8'h3e;
    localparam logic [7:0] CH_SL  = 8'h2f;
    localparam logic [7:0] CH_QM  = 8'h3f;
    localparam logic [7:0] CH_EQ  = 8'h3d;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [2:0] skip_entry;
        logic [4:0] skip_position;
        logic [5:0] skip_length;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       parse_error;
    } out_item_t;

    // Compare engine request / response
    typedef struct packed {
        logic start;
        logic busy;
        logic hit;
    } cmp_ctl_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SP || c == CH_CR || c == CH_LF || c == CH_TAB;
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return c == CH_DQ || c == CH_SQ;
    endfunction

    // Filtered element names, packed first character in the low byte
    function automatic logic elem_filtered(input logic [63:0] nm, input logic [3:0] len);
        logic r;
        r = 1'b0;
        if (len == 4'd4 && nm[31:0] == 32'h65646f6e) r = 1'b1;
        if (len == 4'd3 && nm[23:0] == 24'h796177) r = 1'b1;
        if (len == 4'd8 && nm == 64'h6e6f6974616c6572) r = 1'b1;
        if (len == 4'd6 && nm[47:0] == 48'h7265626d656d) r = 1'b1;
        if (len == 4'd3 && nm[23:0] == 24'h676174) r = 1'b1;
        if (len == 4'd2 && nm[15:0] == 16'h646e) r = 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/xaf_if.sv @@
// ----------------------------------------------------------------------------
// xaf_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
interface xaf_in_if;
    logic               valid;
    logic               ready;
    xaf_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xaf_out_if;
    logic               valid;
    logic               ready;
    xaf_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xaf_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/xml_attribute_filter_unit.sv @@
// ----------------------------------------------------------------------------
// xml_attribute_filter_unit
// Byte-stream XML tag filter with attribute skip table.
// ----------------------------------------------------------------------------
// An item that yields at most one result is taken while the sequencer waits for
// input, and the next can follow at once while the output register is free or
// drains in the same cycle. An opening quote of a kept attribute holds the input
// while the space, the name replayed from its buffer, '=' and the quote go out
// one result a cycle while the output does not stall. A closing single quote
// holds it while the trailing space goes out. On a filtered element the compare
// engine first walks the skip table, skipping each entry of another length and
// reading and comparing each character of an entry of the same length, before
// the name is replayed or the attribute dropped.
module xml_attribute_filter_unit #(
    parameter int SKIP_ENTRIES = xaf_pkg::SKIP_ENTRIES_DEF,
    parameter int MAX_NAME     = xaf_pkg::MAX_NAME_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    xaf_in_if.sink    in_ch,
    xaf_out_if.source out_ch,
    xaf_cfg_if.sink   cfg_ch
);
    import xaf_pkg::*;

    localparam int PW = $clog2(MAX_NAME);

    // Sequencer phases
    localparam logic [2:0] PH_IN   = 3'd0;
    localparam logic [2:0] PH_CMP  = 3'd1;
    localparam logic [2:0] PH_WAIT = 3'd2;
    localparam logic [2:0] PH_EMIT = 3'd3;

    logic [3:0]  st_reg, st_next;
    logic [2:0]  ph_reg, ph_next;
    logic [63:0] en_reg, en_next;
    logic [3:0]  el_reg, el_next;
    logic [7:0]  an_mem [MAX_NAME];
    logic [5:0]  al_reg, al_next;
    logic        sq_reg, sq_next, drop_reg, drop_next, halt_reg, halt_next;
    logic [3:0]  cnt_reg;
    logic [5:0]  ep_reg, ep_next;     // emit sequence index
    logic [1:0]  kind_reg, kind_next; // pending multi-result sequence
    logic        ov_reg, ov_next;
    out_item_t   od_reg, od_next;
    logic        an_we;
    logic [PW-1:0] an_wa;
    logic [PW-1:0] cmp_idx;
    logic [PW-1:0] rd_idx;
    logic        cmp_start;
    cmp_ctl_t    cmp_ctl;
    logic        acc, ofree;
    logic [7:0]  c;

    localparam logic [1:0] K_ATTR = 2'd0;
    localparam logic [1:0] K_SQ   = 2'd1;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= '0;
        else if (cfg_ch.valid) cnt_reg <= cfg_ch.data;
    end

    assign ofree = !ov_reg || out_ch.ready;
    assign in_ch.ready = (ph_reg == PH_IN) && ofree;
    assign acc = in_ch.valid && in_ch.ready;
    assign c   = in_ch.data.data_byte;

    xaf_cmp #(.SKIP_ENTRIES(SKIP_ENTRIES), .MAX_NAME(MAX_NAME)) u_cmp (
        .clk(clk), .rst_n(rst_n),
        .wr_chr(acc && in_ch.data.mode == MODE_SKIPCHR),
        .wr_len(acc && in_ch.data.mode == MODE_SKIPLEN),
        .wr_entry(in_ch.data.skip_entry), .wr_pos(in_ch.data.skip_position),
        .wr_char(c), .wr_length(in_ch.data.skip_length),
        .skip_count(cnt_reg), .name_len(al_reg), .name_chr(an_mem[cmp_idx]),
        .name_idx(cmp_idx), .start(cmp_start), .ctl(cmp_ctl)
    );

    assign rd_idx = PW'(ep_reg - 6'd1);

    always_ff @(posedge clk)
    begin
        if (an_we) an_mem[an_wa] <= c;
    end

    // Main sequencer
    always_comb
    begin
        st_next = st_reg; ph_next = ph_reg; en_next = en_reg; el_next = el_reg;
        al_next = al_reg; sq_next = sq_reg; drop_next = drop_reg;
        halt_next = halt_reg; ep_next = ep_reg; kind_next = kind_reg;
        ov_next = ov_reg && !out_ch.ready; od_next = od_reg;
        an_we = 1'b0; an_wa = al_reg[PW-1:0]; cmp_start = 1'b0;
        unique case (ph_reg)
            PH_IN:
            begin
                if (acc && in_ch.data.mode == MODE_STREAM && !halt_reg)
                begin
                    logic e1, err;
                    logic [7:0] b1;
                    e1 = 1'b0; b1 = c; err = 1'b0;
                    unique case (st_reg)
                        ST_IDLE:
                        begin
                            e1 = 1'b1;
                            if (c == CH_LT) begin st_next = ST_NAME; el_next = '0; end
                        end
                        ST_NAME:
                            if (is_space(c)) st_next = ST_NAME_END;
                            else if (c == CH_GT)
                            begin
                                e1 = 1'b1; st_next = ST_IDLE; el_next = '0;
                            end
                            else
                            begin
                                e1 = 1'b1;
                                if (el_reg < 4'd8) en_next[el_reg[2:0]*8 +: 8] = c;
                                if (el_reg < 4'd9) el_next = el_reg + 4'd1;
                            end
                        ST_NAME_END:
                            if (is_space(c)) ;
                            else if (c == CH_GT)
                            begin
                                e1 = 1'b1; st_next = ST_IDLE; el_next = '0;
                            end
                            else if (c == CH_SL || c == CH_QM)
                            begin
                                e1 = 1'b1; st_next = ST_TAG_END;
                            end
                            else
                            begin
                                an_we = 1'b1; an_wa = '0; al_next = 6'd1;
                                st_next = ST_PNAME;
                            end
                        ST_PNAME:
                            if (is_space(c)) st_next = ST_PNAME_END;
                            else if (c == CH_EQ) st_next = ST_EQU;
                            else if (32'(al_reg) >= MAX_NAME) err = 1'b1;
                            else begin an_we = 1'b1; al_next = al_reg + 6'd1; end
                        ST_PNAME_END:
                            if (is_space(c)) ;
                            else if (c == CH_EQ) st_next = ST_EQU;
                            else err = 1'b1;
                        ST_EQU:
                            if (is_space(c)) ;
                            else if (is_quote(c))
                            begin
                                sq_next = (c == CH_SQ);
                                st_next = ST_VAL;
                                if (elem_filtered(en_reg, el_reg))
                                begin
                                    cmp_start = 1'b1; ph_next = PH_CMP;
                                end
                                else
                                begin
                                    drop_next = 1'b0; ph_next = PH_EMIT;
                                    kind_next = K_ATTR; ep_next = '0;
                                end
                            end
                            else err = 1'b1;
                        ST_VAL:
                            if (is_quote(c))
                            begin
                                if (!drop_reg)
                                begin
                                    e1 = 1'b1;
                                    b1 = sq_reg ? CH_SQ : CH_DQ;
                                    if (sq_reg)
                                    begin
                                        ph_next = PH_EMIT; kind_next = K_SQ;
                                    end
                                end
                                st_next = ST_NAME_END; al_next = '0;
                            end
                            else if (c == CH_CR || c == CH_LF) err = 1'b1;
                            else if (!drop_reg) e1 = 1'b1;
                        ST_TAG_END:
                            if (c == CH_GT)
                            begin
                                e1 = 1'b1; st_next = ST_IDLE; el_next = '0;
                            end
                            else err = 1'b1;
                        default: st_next = ST_IDLE;
                    endcase
                    if (err)
                    begin
                        halt_next = 1'b1; ov_next = 1'b1;
                        od_next = '{out_byte: 8'd0, last: 1'b1, parse_error: 1'b1};
                    end
                    else if (e1)
                    begin
                        ov_next = 1'b1;
                        od_next = '{out_byte: b1, last: (ph_next == PH_IN),
                                    parse_error: 1'b0};
                    end
                end
            end
            PH_CMP: ph_next = PH_WAIT;
            PH_WAIT:
                if (!cmp_ctl.busy)
                begin
                    drop_next = cmp_ctl.hit;
                    ph_next = cmp_ctl.hit ? PH_IN : PH_EMIT;
                    kind_next = K_ATTR; ep_next = '0;
                end
            default: // PH_EMIT: one result a cycle
                if (ofree)
                begin
                    ov_next = 1'b1;
                    if (kind_reg == K_SQ)
                    begin
                        od_next = '{out_byte: CH_SP, last: 1'b1, parse_error: 1'b0};
                        ph_next = PH_IN;
                    end
                    else if (ep_reg == 6'd0)
                    begin
                        od_next = '{out_byte: CH_SP, last: 1'b0, parse_error: 1'b0};
                        ep_next = 6'd1;
                    end
                    else if (ep_reg <= al_reg)
                    begin
                        od_next = '{out_byte: an_mem[rd_idx], last: 1'b0,
                                    parse_error: 1'b0};
                        ep_next = ep_reg + 6'd1;
                    end
                    else if (ep_reg == al_reg + 6'd1)
                    begin
                        od_next = '{out_byte: CH_EQ, last: 1'b0, parse_error: 1'b0};
                        ep_next = ep_reg + 6'd1;
                    end
                    else
                    begin
                        od_next = '{out_byte: sq_reg ? CH_SQ : CH_DQ, last: 1'b1,
                                    parse_error: 1'b0};
                        ph_next = PH_IN;
                    end
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE; ph_reg <= PH_IN; el_reg <= '0; al_reg <= '0;
            sq_reg <= 1'b0; drop_reg <= 1'b0; halt_reg <= 1'b0; ov_reg <= 1'b0;
            ep_reg <= '0; kind_reg <= K_ATTR;
        end
        else
        begin
            st_reg <= st_next; ph_reg <= ph_next; el_reg <= el_next;
            al_reg <= al_next; sq_reg <= sq_next; drop_reg <= drop_next;
            halt_reg <= halt_next; ov_reg <= ov_next; ep_reg <= ep_next;
            kind_reg <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        en_reg <= en_next;
        od_reg <= od_next;
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;
endmodule

@@ rtl/xaf_cmp.sv @@
// ----------------------------------------------------------------------------
// xaf_cmp
// Skip table store and serial name compare, reading then comparing each character.
// ----------------------------------------------------------------------------
module xaf_cmp #(
    parameter int SKIP_ENTRIES = xaf_pkg::SKIP_ENTRIES_DEF,
    parameter int MAX_NAME     = xaf_pkg::MAX_NAME_DEF,
    parameter int EW           = (SKIP_ENTRIES > 1) ? $clog2(SKIP_ENTRIES) : 1,
    parameter int PW           = $clog2(MAX_NAME)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_chr,
    input  logic              wr_len,
    input  logic [2:0]        wr_entry,
    input  logic [4:0]        wr_pos,
    input  logic [7:0]        wr_char,
    input  logic [5:0]        wr_length,
    input  logic [3:0]        skip_count,
    input  logic [5:0]        name_len,
    input  logic [7:0]        name_chr,
    output logic [PW-1:0]     name_idx,
    input  logic              start,
    output xaf_pkg::cmp_ctl_t ctl
);
    import xaf_pkg::*;

    localparam int DEPTH = SKIP_ENTRIES * MAX_NAME;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]  mem [DEPTH];
    logic [5:0]  len_reg [SKIP_ENTRIES];
    logic [7:0]  rd_reg;
    logic [6:0]  ent_reg, ent_next;
    logic [5:0]  pos_reg, pos_next;
    logic        busy_reg, busy_next, hit_reg, hit_next, rdv_reg, rdv_next;
    logic        match_reg, match_next;
    logic [6:0]  used;
    logic [EW-1:0] ent_idx;
    logic        wr_ok;

    assign used    = (7'(skip_count) < 7'(SKIP_ENTRIES)) ? 7'(skip_count)
                                                         : 7'(SKIP_ENTRIES);
    assign ent_idx = ent_reg[EW-1:0];
    assign wr_ok   = (32'(wr_entry) < SKIP_ENTRIES) && (32'(wr_pos) < MAX_NAME);
    assign name_idx = pos_reg[PW-1:0];

    // Character store, registered read
    always_ff @(posedge clk)
    begin
        if (wr_chr && wr_ok)
            mem[AW'(32'(wr_entry) * MAX_NAME + 32'(wr_pos))] <= wr_char;
        rd_reg <= mem[AW'(32'(ent_idx) * MAX_NAME + 32'(pos_reg))];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SKIP_ENTRIES; i++) len_reg[i] <= '0;
        end
        else if (wr_len && 32'(wr_entry) < SKIP_ENTRIES)
            len_reg[wr_entry[EW-1:0]] <= wr_length;
    end

    // Sequencer: walk entries; per entry, read then compare each character
    always_comb
    begin
        ent_next   = ent_reg;
        pos_next   = pos_reg;
        busy_next  = busy_reg;
        hit_next   = hit_reg;
        rdv_next   = 1'b0;
        match_next = match_reg;
        if (start)
        begin
            busy_next = 1'b1;
            hit_next  = 1'b0;
            ent_next  = '0;
            pos_next  = '0;
            match_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ent_reg >= used)
                busy_next = 1'b0;
            else if (len_reg[ent_idx] != name_len)
            begin
                ent_next = ent_reg + 7'd1;
                pos_next = '0;
            end
            else if (!rdv_reg)
            begin
                if (pos_reg == name_len)
                begin
                    hit_next  = 1'b1;
                    busy_next = 1'b0;
                end
                else
                    rdv_next = 1'b1;
            end
            else if (rd_reg != name_chr)
            begin
                ent_next = ent_reg + 7'd1;
                pos_next = '0;
            end
            else
                pos_next = pos_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            hit_reg  <= 1'b0;
            rdv_reg  <= 1'b0;
            ent_reg  <= '0;
            pos_reg  <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            hit_reg  <= hit_next;
            rdv_reg  <= rdv_next;
            ent_reg  <= ent_next;
            pos_reg  <= pos_next;
            match_reg <= match_next;
        end
    end

    assign ctl.start = start && match_reg | start;
    assign ctl.busy  = busy_reg;
    assign ctl.hit   = hit_reg;
endmodule

@@ rtl/xaf_checker.sv @@
// ----------------------------------------------------------------------------
// xaf_checker
// Port-level checks of the attribute filter, bound to the top level.
// ----------------------------------------------------------------------------
module xaf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_err
);
    // A result held under stall keeps its flags
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_last) && $stable(out_err))
        else $error("stalled result changed");

    // An error result always closes its item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_last)
        else $error("error result without last");

    // Input is not taken while a result is stalled
    a_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken under output stall");

    // An error just delivered is not followed at once by another error result
    a_one_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_err |=> !(out_valid && out_err))
        else $error("repeated error result");
endmodule

bind xml_attribute_filter_unit xaf_checker u_xaf_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.data.last), .out_err(out_ch.data.parse_error)
);
